### design/sfp_pkg.sv
// Shared types, constants and the rate-code decoder for the OFDM SIGNAL field parser.
// Used by every module of the block and by its checker. No dependencies.

package sfp_pkg;

  localparam int SigWidth    = 18;
  localparam int LenWidth    = 12;
  localparam int SymWidth    = 11;
  localparam int NumWidth    = 16;  // service + 8*length + tail + divisor - 1
  localparam int QuotWidth   = 14;  // dividend after the power-of-two shift
  localparam int RecipShift  = 19;
  localparam int RecipWidth  = 18;
  localparam int ProdWidth   = QuotWidth + RecipWidth;

  localparam int QueueDepthDef = 4;

  // service (16) plus tail (6) bits
  localparam logic [NumWidth-1:0] FixedBits = NumWidth'(22);

  // ceil(2^19 / m); exact for every dividend below 2^14
  localparam logic [RecipWidth-1:0] Recip3  = RecipWidth'(((1 << RecipShift) + 2) / 3);
  localparam logic [RecipWidth-1:0] Recip9  = RecipWidth'(((1 << RecipShift) + 8) / 9);
  localparam logic [RecipWidth-1:0] Recip27 = RecipWidth'(((1 << RecipShift) + 26) / 27);

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_PARITY = 2'd1,
    ST_RATE   = 2'd2
  } sfp_status_t;

  typedef enum logic [1:0] {
    DIV3  = 2'd0,
    DIV9  = 2'd1,
    DIV27 = 2'd2
  } sfp_div_t;

  typedef enum logic [1:0] {
    MOD_BPSK  = 2'd0,
    MOD_QPSK  = 2'd1,
    MOD_QAM16 = 2'd2,
    MOD_QAM64 = 2'd3
  } sfp_mod_t;

  typedef enum logic [3:0] {
    RC_6M  = 4'd11,
    RC_9M  = 4'd15,
    RC_12M = 4'd10,
    RC_18M = 4'd14,
    RC_24M = 4'd9,
    RC_36M = 4'd13,
    RC_48M = 4'd8,
    RC_54M = 4'd12
  } sfp_rate_code_t;

  typedef struct packed {
    logic       known;
    logic [2:0] enc;
    logic [1:0] modn;
    logic [7:0] dbps_m1;  // bits per symbol minus one
    logic [2:0] shift;    // power-of-two part of bits per symbol
    sfp_div_t   dsel;     // odd part: 3, 9 or 27
  } sfp_rate_t;

  // one classified item, as held in the queue
  typedef struct packed {
    sfp_status_t          status;
    logic [2:0]           enc;
    logic [1:0]           modn;
    logic [LenWidth-1:0]  len;
    logic [QuotWidth-1:0] quot;
    sfp_div_t             dsel;
  } sfp_entry_t;

  function automatic sfp_rate_t rate_lookup(input logic [3:0] code);
    sfp_rate_t r;
    r = '{known: 1'b0, enc: 3'd0, modn: 2'd0, dbps_m1: 8'd0, shift: 3'd0, dsel: DIV3};
    unique case (code)
      RC_6M:   r = '{1'b1, 3'd0, MOD_BPSK,  8'd23,  3'd3, DIV3};
      RC_9M:   r = '{1'b1, 3'd1, MOD_BPSK,  8'd35,  3'd2, DIV9};
      RC_12M:  r = '{1'b1, 3'd2, MOD_QPSK,  8'd47,  3'd4, DIV3};
      RC_18M:  r = '{1'b1, 3'd3, MOD_QPSK,  8'd71,  3'd3, DIV9};
      RC_24M:  r = '{1'b1, 3'd4, MOD_QAM16, 8'd95,  3'd5, DIV3};
      RC_36M:  r = '{1'b1, 3'd5, MOD_QAM16, 8'd143, 3'd4, DIV9};
      RC_48M:  r = '{1'b1, 3'd6, MOD_QAM64, 8'd191, 3'd6, DIV3};
      RC_54M:  r = '{1'b1, 3'd7, MOD_QAM64, 8'd215, 3'd3, DIV27};
      default: r = '{1'b0, 3'd0, 2'd0,      8'd0,   3'd0, DIV3};
    endcase
    return r;
  endfunction

  function automatic logic [RecipWidth-1:0] recip_of(input sfp_div_t d);
    logic [RecipWidth-1:0] v;
    v = Recip3;
    unique case (d)
      DIV3:    v = Recip3;
      DIV9:    v = Recip9;
      DIV27:   v = Recip27;
      default: v = Recip3;
    endcase
    return v;
  endfunction

endpackage

### design/ofdm_signal_field_parser_top.sv
// OFDM SIGNAL field parser, top level.
// Usage:
//   Input channel: sig_valid / sig_stall with the 18 decoded SIGNAL bits on
//   signal_bits. A word is taken on a rising edge with sig_valid high and
//   sig_stall low. Output channel: res_valid / res_stall with status,
//   encoding, frame_length_bytes, frame_symbol_count and modulation; one
//   result per word, in order.
//   Throughput: one word per cycle, sustained, for as long as the receiver
//   takes results; the single 14x18 reciprocal multiply is pipelined.
//   Path: a taken word is registered in the queue, then in the multiply
//   register, then in the output register.
//   The symbol count is ceil(total bits / bits per symbol), worked as a
//   power-of-two shift followed by a multiply by the reciprocal of 3, 9 or 27.
//   Stall: when res_stall is high the result holds; the pipeline and then
//   the QUEUE_DEPTH-entry queue fill, after which sig_stall rises.
//   Reset (rst, synchronous): empties the queue and the pipeline; no item
//   state survives. No clearing pass is needed.
// Depends on sfp_pkg, sfp_front, sfp_queue, sfp_back.

module ofdm_signal_field_parser_top
  import sfp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sig_valid,
  output logic                sig_stall,
  input  logic [SigWidth-1:0] signal_bits,
  output logic                res_valid,
  input  logic                res_stall,
  output logic [1:0]          status,
  output logic [2:0]          encoding,
  output logic [LenWidth-1:0] frame_length_bytes,
  output logic [SymWidth-1:0] frame_symbol_count,
  output logic [1:0]          modulation
);

  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_nonempty;
  sfp_entry_t push_entry;
  sfp_entry_t head;

  sfp_front u_front (
    .sig_valid  (sig_valid),
    .signal_bits(signal_bits),
    .queue_full (q_full),
    .sig_stall  (sig_stall),
    .push       (push),
    .push_entry (push_entry)
  );

  sfp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .full      (q_full),
    .nonempty  (q_nonempty),
    .head      (head)
  );

  sfp_back u_back (
    .clk               (clk),
    .rst               (rst),
    .head_valid        (q_nonempty),
    .head              (head),
    .pop               (pop),
    .res_valid         (res_valid),
    .res_stall         (res_stall),
    .status            (status),
    .encoding          (encoding),
    .frame_length_bytes(frame_length_bytes),
    .frame_symbol_count(frame_symbol_count),
    .modulation        (modulation)
  );

endmodule

### design/sfp_front.sv
// Front end: takes SIGNAL words, checks parity, decodes the rate code and
// prepares the shifted dividend. Depends on sfp_pkg.

module sfp_front
  import sfp_pkg::*;
(
  input  logic                sig_valid,
  input  logic [SigWidth-1:0] signal_bits,
  input  logic                queue_full,
  output logic                sig_stall,
  output logic                push,
  output sfp_entry_t          push_entry
);

  sfp_rate_t           rate;
  logic                par_bad;
  logic [LenWidth-1:0] len;
  logic [NumWidth-1:0] num;
  logic [NumWidth-1:0] num_sh;

  assign sig_stall = queue_full;
  assign push      = sig_valid && !queue_full;

  always_comb begin
    rate    = rate_lookup(signal_bits[3:0]);
    par_bad = (^signal_bits[16:0]) != signal_bits[17];
    len     = signal_bits[16:5];
    // ceil(total / d) = floor((total + d - 1) / d), power-of-two part first
    num     = {1'b0, len, 3'b000} + FixedBits + NumWidth'(rate.dbps_m1);
    num_sh  = num >> rate.shift;

    push_entry.len = len;
    if (par_bad) begin
      push_entry.status = ST_PARITY;
    end else if (!rate.known) begin
      push_entry.status = ST_RATE;
    end else begin
      push_entry.status = ST_OK;
    end

    if (!par_bad && rate.known) begin
      push_entry.enc  = rate.enc;
      push_entry.modn = rate.modn;
      push_entry.quot = num_sh[QuotWidth-1:0];
      push_entry.dsel = rate.dsel;
    end else begin
      // zero dividend yields a zero symbol count downstream
      push_entry.enc  = 3'd0;
      push_entry.modn = 2'd0;
      push_entry.quot = '0;
      push_entry.dsel = DIV3;
    end
  end

endmodule

### design/sfp_queue.sv
// Short FIFO of classified items between the front and back ends.
// Depends on sfp_pkg.

module sfp_queue
  import sfp_pkg::*;
#(
  parameter int DEPTH = QueueDepthDef
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  sfp_entry_t push_entry,
  input  logic       pop,
  output logic       full,
  output logic       nonempty,
  output sfp_entry_t head
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  sfp_entry_t          mem [DEPTH];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;
  logic [CntW-1:0]     count_next;

  assign full     = (count == CntW'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !(pop && nonempty)) begin
      count_next = count + CntW'(1);
    end else if (!push && pop && nonempty) begin
      count_next = count - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop && nonempty) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
    end
  end

endmodule

### design/sfp_back.sv
// Back end: reciprocal multiply for the symbol count, then the output register.
// Depends on sfp_pkg.

module sfp_back
  import sfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  sfp_entry_t          head,
  output logic                pop,
  output logic                res_valid,
  input  logic                res_stall,
  output logic [1:0]          status,
  output logic [2:0]          encoding,
  output logic [LenWidth-1:0] frame_length_bytes,
  output logic [SymWidth-1:0] frame_symbol_count,
  output logic [1:0]          modulation
);

  // multiply stage
  logic                 mul_valid;
  sfp_status_t          mul_status;
  logic [2:0]           mul_enc;
  logic [1:0]           mul_modn;
  logic [LenWidth-1:0]  mul_len;
  logic [ProdWidth-1:0] mul_prod;

  logic out_adv;
  logic mul_adv;

  assign out_adv = !res_valid || !res_stall;
  assign mul_adv = !mul_valid || out_adv;
  assign pop     = head_valid && mul_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (mul_adv) begin
        mul_valid <= head_valid;
      end
      if (out_adv) begin
        res_valid <= mul_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mul_status <= head.status;
      mul_enc    <= head.enc;
      mul_modn   <= head.modn;
      mul_len    <= head.len;
      mul_prod   <= ProdWidth'(head.quot) * ProdWidth'(recip_of(head.dsel));
    end
    if (out_adv && mul_valid) begin
      status             <= mul_status;
      encoding           <= mul_enc;
      modulation         <= mul_modn;
      frame_length_bytes <= mul_len;
      frame_symbol_count <= mul_prod[RecipShift +: SymWidth];
    end
  end

endmodule

### design/sfp_checker.sv
// Port-level checks for the OFDM SIGNAL field parser, bound to the top level.
// Depends on sfp_pkg and ofdm_signal_field_parser_top.

module sfp_checker
  import sfp_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                res_valid,
  input logic                res_stall,
  input logic [1:0]          status,
  input logic [2:0]          encoding,
  input logic [LenWidth-1:0] frame_length_bytes,
  input logic [SymWidth-1:0] frame_symbol_count,
  input logic [1:0]          modulation
);

  // nothing comes out in the cycle after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid straight after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(status) && $stable(encoding)
      && $stable(frame_length_bytes) && $stable(frame_symbol_count)
      && $stable(modulation))
    else $error("stalled result changed");

  // failed words carry zero encoding, count and modulation
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == ST_PARITY || status == ST_RATE)
      |-> encoding == 3'd0 && frame_symbol_count == '0 && modulation == 2'd0)
    else $error("error result with non-zero fields");

  // a good word always needs at least one symbol
  a_ok_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_OK |-> frame_symbol_count != '0)
    else $error("good result with zero symbol count");

  // modulation follows encoding pairs
  a_mod_enc: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_OK |-> modulation == encoding[2:1])
    else $error("modulation does not match encoding");

endmodule

bind ofdm_signal_field_parser_top sfp_checker u_sfp_checker (.*);

### test/tb_ofdm_signal_field_parser_top.sv
// Testbench for ofdm_signal_field_parser_top: directed and random SIGNAL words, every
// result checked field by field against an in-bench decoder of the SIGNAL field.
// Depends on sfp_pkg and the parser RTL; self-contained, no files or arguments.

module tb_ofdm_signal_field_parser_top;
  import sfp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit  = 2000;  // cycles without any transaction

  typedef struct packed {
    sfp_status_t         status;
    logic [2:0]          enc;
    logic [LenWidth-1:0] len;
    logic [SymWidth-1:0] syms;
    logic [1:0]          modn;
  } sig_result_t;

  localparam sfp_rate_code_t RateCodes[8] = '{RC_6M, RC_9M, RC_12M, RC_18M,
                                              RC_24M, RC_36M, RC_48M, RC_54M};

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                sig_valid = 1'b0;
  logic                sig_stall;
  logic [SigWidth-1:0] signal_bits = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  logic [1:0]          status;
  logic [2:0]          encoding;
  logic [LenWidth-1:0] frame_length_bytes;
  logic [SymWidth-1:0] frame_symbol_count;
  logic [1:0]          modulation;

  sig_result_t pending_results[$];
  int unsigned error_count = 0;
  int unsigned words_sent = 0;
  int unsigned ok_seen = 0, parity_seen = 0, rate_seen = 0;
  int unsigned idle_cycles = 0;

  // sender and receiver idling controls, set per test
  int unsigned gap_max = 0, burst_max = 1, burst_left = 0;
  int unsigned stall_pct = 0, stall_max = 1, stall_hold = 0;
  logic        stall_now;

  ofdm_signal_field_parser_top uut (
    .clk               (clk),
    .rst               (rst),
    .sig_valid         (sig_valid),
    .sig_stall         (sig_stall),
    .signal_bits       (signal_bits),
    .res_valid         (res_valid),
    .res_stall         (res_stall),
    .status            (status),
    .encoding          (encoding),
    .frame_length_bytes(frame_length_bytes),
    .frame_symbol_count(frame_symbol_count),
    .modulation        (modulation)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic sig_result_t decode_signal_word(input logic [SigWidth-1:0] w);
    sig_result_t r;
    int unsigned bps;
    int unsigned total;
    r = '0;
    r.status = ST_OK;
    r.len = w[16:5];
    bps = 0;
    case (sfp_rate_code_t'(w[3:0]))
      RC_6M:   begin r.enc = 3'd0; r.modn = MOD_BPSK;  bps = 24;  end
      RC_9M:   begin r.enc = 3'd1; r.modn = MOD_BPSK;  bps = 36;  end
      RC_12M:  begin r.enc = 3'd2; r.modn = MOD_QPSK;  bps = 48;  end
      RC_18M:  begin r.enc = 3'd3; r.modn = MOD_QPSK;  bps = 72;  end
      RC_24M:  begin r.enc = 3'd4; r.modn = MOD_QAM16; bps = 96;  end
      RC_36M:  begin r.enc = 3'd5; r.modn = MOD_QAM16; bps = 144; end
      RC_48M:  begin r.enc = 3'd6; r.modn = MOD_QAM64; bps = 192; end
      RC_54M:  begin r.enc = 3'd7; r.modn = MOD_QAM64; bps = 216; end
      default: bps = 0;
    endcase
    if ((^w[16:0]) != w[17]) begin
      r.status = ST_PARITY;
      r.enc = '0;
      r.modn = '0;
    end else if (bps == 0) begin
      r.status = ST_RATE;
      r.enc = '0;
      r.modn = '0;
    end else begin
      // service + tail bits, rounded up to whole symbols
      total = 22 + 8 * r.len;
      r.syms = SymWidth'((total + bps - 1) / bps);
    end
    return r;
  endfunction

  function automatic logic [SigWidth-1:0] make_signal_word(input logic [3:0] code,
      input logic rsvd, input logic [LenWidth-1:0] len, input logic bad_parity);
    logic [16:0] body;
    body = {len, rsvd, code};
    return {(^body) ^ bad_parity, body};
  endfunction

  task automatic compare_field(input string fname, input logic [15:0] exp_v,
      input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v, act_v);
    end
  endtask

  // input monitor, output checker and watchdog share one sampling point
  always @(posedge clk) begin
    sig_result_t exp_r;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (sig_valid && !sig_stall)
        pending_results.push_back(decode_signal_word(signal_bits));
      if (res_valid && !res_stall) begin
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t ns: result with nothing expected, expected none, actual status %0d",
                   $time, status);
        end else begin
          exp_r = pending_results.pop_front();
          compare_field("status", 16'(exp_r.status), 16'(status));
          compare_field("encoding", 16'(exp_r.enc), 16'(encoding));
          compare_field("frame_length_bytes", 16'(exp_r.len), 16'(frame_length_bytes));
          compare_field("frame_symbol_count", 16'(exp_r.syms), 16'(frame_symbol_count));
          compare_field("modulation", 16'(exp_r.modn), 16'(modulation));
          case (exp_r.status)
            ST_OK:     ok_seen++;
            ST_PARITY: parity_seen++;
            default:   rate_seen++;
          endcase
        end
      end
      if ((sig_valid && !sig_stall) || (res_valid && !res_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("%0t ns: no transaction for %0d cycles", $time, IdleLimit);
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver: alternating free and stalled runs
  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      stall_now = !res_stall && stall_pct != 0 && $urandom_range(99) < stall_pct;
      res_stall <= stall_now;
      stall_hold <= stall_now ? $urandom_range(stall_max - 1) : $urandom_range(7);
    end
  end

  task automatic send_word(input logic [SigWidth-1:0] w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(gap_max);
      if (gap != 0) begin
        sig_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, burst_max);
    end
    burst_left--;
    sig_valid <= 1'b1;
    signal_bits <= w;
    @(posedge clk);
    while (sig_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic test_valid_rates();
    foreach (RateCodes[i]) begin
      send_word(make_signal_word(RateCodes[i], 1'b0, 12'd0, 1'b0));
      send_word(make_signal_word(RateCodes[i], 1'b0, 12'd4095, 1'b0));
    end
  endtask

  task automatic test_error_cases();
    send_word(make_signal_word(RC_54M, 1'b1, 12'd4095, 1'b1));  // parity, valid code
    send_word(make_signal_word(4'd3, 1'b0, 12'd100, 1'b1));     // parity, unknown code
    send_word(make_signal_word(4'd0, 1'b0, 12'd4095, 1'b0));    // unknown code
    send_word(make_signal_word(4'd7, 1'b1, 12'd1, 1'b0));       // unknown code
    send_word(make_signal_word(RC_6M, 1'b1, 12'd2730, 1'b0));   // reserved bit set
    send_word('0);
    send_word('1);
  endtask

  task automatic test_random_frames(input int unsigned n, input int unsigned gmax,
      input int unsigned bmax, input int unsigned spct, input int unsigned smax);
    int unsigned sel;
    int unsigned lsel;
    logic [LenWidth-1:0] len;
    gap_max = gmax;
    burst_max = bmax;
    stall_pct = spct;
    stall_max = smax;
    repeat (n) begin
      sel = $urandom_range(99);
      lsel = $urandom_range(99);
      if (lsel < 25)
        len = LenWidth'($urandom_range(31));
      else if (lsel < 90)
        len = LenWidth'($urandom);
      else
        len = lsel[0] ? '1 : '0;
      if (sel < 70)
        send_word(make_signal_word(RateCodes[3'($urandom_range(7))], 1'($urandom), len,
                                   1'b0));
      else if (sel < 85)
        send_word(make_signal_word(4'($urandom), 1'($urandom), len, 1'b1));
      else
        send_word(make_signal_word(4'($urandom_range(7)), 1'($urandom), len, 1'b0));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    burst_max = 4;
    gap_max = 2;
    test_valid_rates();
    test_error_cases();
    test_random_frames(400, 0, 1, 0, 1);
    test_random_frames(400, 6, 10, 30, 8);
    test_random_frames(400, 2, 30, 60, 30);
    test_random_frames(400, 12, 3, 10, 3);

    sig_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d SIGNAL words under varied gaps and result stalls.", words_sent);
    $display("Results checked: %0d ok, %0d parity error, %0d unknown rate; %0d mismatches.",
             ok_seen, parity_seen, rate_seen, error_count);
    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
design/sfp_pkg.sv
design/sfp_front.sv
design/sfp_queue.sv
design/sfp_back.sv
design/ofdm_signal_field_parser_top.sv
design/sfp_checker.sv
test/tb_ofdm_signal_field_parser_top.sv
